// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by two_vector_attitude_rotation.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("assertion failed");
`define ASSERT_DELAY(lbl, clk, rstn, pre, post, dly) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> ##dly (post)) \
        else $error("latency assertion failed");
`else
`define ASSERT_IMPLY(lbl, clk, rstn, pre, post)
`define ASSERT_DELAY(lbl, clk, rstn, pre, post, dly)
`endif
`endif

// ===== hw/rtl/tvar_pkg.sv =====
package tvar_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int SW    = SAMPLE_WIDTH;
    // Cross product of two samples.
    localparam int NW    = 2 * SW + 1;
    // Cross product of a sample and a cross product.
    localparam int MW    = 3 * SW + 2;
    // Squared norm of n, unsigned.
    localparam int NNW   = 4 * SW;
    // Numerator of one rotation entry.
    localparam int PW    = 4 * SW + 2;
    // Partial remainder of the quotient pipeline.
    localparam int RW    = 4 * SW + 34;
    localparam int FRAC  = 24;
    localparam int QBITS = 32;
    localparam int OW    = 32;
    // Input register, four arithmetic stages, quotient stages, output register.
    localparam int LAT_CYCLES = QBITS + 6;

    localparam logic [OW-1:0] SAT_POS = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] SAT_NEG = {1'b1, {(OW-1){1'b0}}};

    localparam logic signed [SW-1:0] RESET_ZERO = '0;
    localparam logic signed [SW-1:0] RESET_ONE  = SW'(16384);

    typedef enum logic [2:0] {
        REG_GRAV_X = 3'd0,
        REG_GRAV_Y = 3'd1,
        REG_GRAV_Z = 3'd2,
        REG_MAG_X  = 3'd3,
        REG_MAG_Y  = 3'd4,
        REG_MAG_Z  = 3'd5
    } reg_idx_t;

endpackage

// ===== hw/rtl/two_vector_attitude_rotation.sv =====
// Two-vector attitude rotation. One transaction can be started in every clock cycle
// (busy is always low) and its nine Q8.24 entries of R and the singular flag appear
// for one cycle with done high; the receiver cannot stall, so results must be taken
// as they appear. A transaction passes an input register, three multiply stages and
// a quotient setup stage, then a 32-stage restoring divider (one quotient bit per
// stage, per matrix entry) and an output register. Reference vectors are written
// through wr_en, wr_index and wr_data by the user only while no transaction is in
// flight; the block does not enforce this. Indexes 6 and 7 are ignored.
`include "assert_macros.svh"

module two_vector_attitude_rotation (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [tvar_pkg::SW-1:0]        obs_grav_x,
    input  logic signed [tvar_pkg::SW-1:0]        obs_grav_y,
    input  logic signed [tvar_pkg::SW-1:0]        obs_grav_z,
    input  logic signed [tvar_pkg::SW-1:0]        obs_mag_x,
    input  logic signed [tvar_pkg::SW-1:0]        obs_mag_y,
    input  logic signed [tvar_pkg::SW-1:0]        obs_mag_z,
    input  logic                                  wr_en,
    input  logic [2:0]                            wr_index,
    input  logic [tvar_pkg::SW-1:0]               wr_data,
    output logic                                  done,
    output logic signed [tvar_pkg::OW-1:0]        rot_00,
    output logic signed [tvar_pkg::OW-1:0]        rot_01,
    output logic signed [tvar_pkg::OW-1:0]        rot_02,
    output logic signed [tvar_pkg::OW-1:0]        rot_10,
    output logic signed [tvar_pkg::OW-1:0]        rot_11,
    output logic signed [tvar_pkg::OW-1:0]        rot_12,
    output logic signed [tvar_pkg::OW-1:0]        rot_20,
    output logic signed [tvar_pkg::OW-1:0]        rot_21,
    output logic signed [tvar_pkg::OW-1:0]        rot_22,
    output logic                                  singular
);

    localparam int SW    = tvar_pkg::SW;
    localparam int NW    = tvar_pkg::NW;
    localparam int MW    = tvar_pkg::MW;
    localparam int NNW   = tvar_pkg::NNW;
    localparam int PW    = tvar_pkg::PW;
    localparam int RW    = tvar_pkg::RW;
    localparam int QBITS = tvar_pkg::QBITS;
    localparam int OW    = tvar_pkg::OW;

    // Configuration registers.
    logic signed [SW-1:0] cfg_reg [6];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg[tvar_pkg::REG_GRAV_X] <= tvar_pkg::RESET_ZERO;
            cfg_reg[tvar_pkg::REG_GRAV_Y] <= tvar_pkg::RESET_ZERO;
            cfg_reg[tvar_pkg::REG_GRAV_Z] <= tvar_pkg::RESET_ONE;
            cfg_reg[tvar_pkg::REG_MAG_X]  <= tvar_pkg::RESET_ONE;
            cfg_reg[tvar_pkg::REG_MAG_Y]  <= tvar_pkg::RESET_ZERO;
            cfg_reg[tvar_pkg::REG_MAG_Z]  <= tvar_pkg::RESET_ZERO;
        end
        else if (wr_en)
        begin
            unique case (tvar_pkg::reg_idx_t'(wr_index))
                tvar_pkg::REG_GRAV_X: cfg_reg[tvar_pkg::REG_GRAV_X] <= wr_data;
                tvar_pkg::REG_GRAV_Y: cfg_reg[tvar_pkg::REG_GRAV_Y] <= wr_data;
                tvar_pkg::REG_GRAV_Z: cfg_reg[tvar_pkg::REG_GRAV_Z] <= wr_data;
                tvar_pkg::REG_MAG_X:  cfg_reg[tvar_pkg::REG_MAG_X]  <= wr_data;
                tvar_pkg::REG_MAG_Y:  cfg_reg[tvar_pkg::REG_MAG_Y]  <= wr_data;
                tvar_pkg::REG_MAG_Z:  cfg_reg[tvar_pkg::REG_MAG_Z]  <= wr_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // Valid bits of the arithmetic stages.
    logic valid1_reg, valid2_reg, valid3_reg, valid4_reg;
    logic [QBITS:0] div_valid_reg;
    logic done_reg;

    // Stage 1: captured vectors.
    logic signed [SW-1:0] g1_reg [3], m1_reg [3], go1_reg [3], mo1_reg [3];
    // Stage 2: n = m x g and no = mo x go.
    logic signed [SW-1:0] g2_reg [3], m2_reg [3], go2_reg [3], mo2_reg [3];
    logic signed [NW-1:0] n2_reg [3], no2_reg [3];
    logic signed [NW-1:0] n2_next [3], no2_next [3];
    // Stage 3: n.n, m x n and n x g.
    logic signed [SW-1:0] go3_reg [3], mo3_reg [3];
    logic signed [NW-1:0] n3_reg [3], no3_reg [3];
    logic signed [MW-1:0] mn3_reg [3], ng3_reg [3];
    logic signed [MW-1:0] mn3_next [3], ng3_next [3];
    logic [NNW-1:0]       nn3_reg, nn3_next;
    logic signed [2*NW-1:0] sq_sum;
    // Stage 4: numerators.
    logic signed [PW-1:0] num4_reg [3][3], num4_next [3][3];
    logic [NNW-1:0]       nn4_reg;
    logic                 sing4_reg;

    // Quotient pipeline, index 0 is loaded from stage 4.
    logic [RW-1:0]    rem_reg  [QBITS+1][3][3];
    logic [RW-1:0]    rem_next [QBITS+1][3][3];
    logic [QBITS-1:0] q_reg    [QBITS+1][3][3];
    logic [QBITS-1:0] q_next   [QBITS+1][3][3];
    logic             neg_reg  [QBITS+1][3][3];
    logic             sat_reg  [QBITS+1][3][3];
    logic             neg0_next [3][3], sat0_next [3][3];
    logic [RW-1:0]    div_d_reg [QBITS+1];
    logic [RW-1:0]    d0_next;
    logic [QBITS:0]   div_sing_reg;
    logic             div_chk;

    logic [OW-1:0] rot_reg [3][3], rot_next [3][3];
    logic          sing_out_reg;

    // Products for the cross products, one generate lane per component.
    for (genvar i = 0; i < 3; i++)
    begin : g_cross
        localparam int I1 = (i + 1) % 3;
        localparam int I2 = (i + 2) % 3;
        assign n2_next[i]  = NW'(m1_reg[I1] * g1_reg[I2]) - NW'(m1_reg[I2] * g1_reg[I1]);
        assign no2_next[i] = NW'(mo1_reg[I1] * go1_reg[I2]) - NW'(mo1_reg[I2] * go1_reg[I1]);
        assign mn3_next[i] = MW'(m2_reg[I1] * n2_reg[I2]) - MW'(m2_reg[I2] * n2_reg[I1]);
        assign ng3_next[i] = MW'(n2_reg[I1] * g2_reg[I2]) - MW'(n2_reg[I2] * g2_reg[I1]);
    end

    assign sq_sum = (n2_reg[0] * n2_reg[0]) + (n2_reg[1] * n2_reg[1])
                  + (n2_reg[2] * n2_reg[2]);
    assign nn3_next = sq_sum[NNW-1:0];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                num4_next[i][j] = PW'(no3_reg[i] * n3_reg[j]) - PW'(go3_reg[i] * mn3_reg[j])
                                - PW'(mo3_reg[i] * ng3_reg[j]);
            end
        end
    end

    // Quotient setup: T = |num| * 2^25 + N over D = 2N gives the rounded magnitude.
    always_comb
    begin
        logic [PW-1:0] mag;
        logic [RW-1:0] dend;
        d0_next = RW'({nn4_reg, 1'b0});
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                neg0_next[i][j] = num4_reg[i][j][PW-1];
                mag = neg0_next[i][j] ? (~num4_reg[i][j] + 1'b1) : num4_reg[i][j];
                dend = (RW'(mag) << (tvar_pkg::FRAC + 1)) + RW'(nn4_reg);
                rem_next[0][i][j] = dend;
                q_next[0][i][j] = '0;
                sat0_next[i][j] = dend >= (d0_next << QBITS);
            end
        end
        // One restoring step per stage, most significant quotient bit first.
        for (int s = 1; s <= QBITS; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rem_next[s][i][j] = rem_reg[s-1][i][j];
                    q_next[s][i][j] = q_reg[s-1][i][j];
                    if (rem_reg[s-1][i][j] >= (div_d_reg[s-1] << (QBITS - s)))
                    begin
                        rem_next[s][i][j] = rem_reg[s-1][i][j]
                                          - (div_d_reg[s-1] << (QBITS - s));
                        q_next[s][i][j][QBITS-s] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb
    begin
        logic [OW-1:0] lim;
        logic [OW-1:0] mag32;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                lim = neg_reg[QBITS][i][j] ? tvar_pkg::SAT_NEG : tvar_pkg::SAT_POS;
                mag32 = OW'(q_reg[QBITS][i][j]);
                if (sat_reg[QBITS][i][j] || (mag32 > lim))
                begin
                    mag32 = lim;
                end
                rot_next[i][j] = neg_reg[QBITS][i][j] ? (~mag32 + 1'b1) : mag32;
                if (div_sing_reg[QBITS])
                begin
                    rot_next[i][j] = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg    <= 1'b0;
            valid2_reg    <= 1'b0;
            valid3_reg    <= 1'b0;
            valid4_reg    <= 1'b0;
            div_valid_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            valid1_reg    <= start;
            valid2_reg    <= valid1_reg;
            valid3_reg    <= valid2_reg;
            valid4_reg    <= valid3_reg;
            div_valid_reg <= {div_valid_reg[QBITS-1:0], valid4_reg};
            done_reg      <= div_valid_reg[QBITS];
        end
    end

    always_ff @(posedge clk)
    begin
        g1_reg[0]  <= cfg_reg[tvar_pkg::REG_GRAV_X];
        g1_reg[1]  <= cfg_reg[tvar_pkg::REG_GRAV_Y];
        g1_reg[2]  <= cfg_reg[tvar_pkg::REG_GRAV_Z];
        m1_reg[0]  <= cfg_reg[tvar_pkg::REG_MAG_X];
        m1_reg[1]  <= cfg_reg[tvar_pkg::REG_MAG_Y];
        m1_reg[2]  <= cfg_reg[tvar_pkg::REG_MAG_Z];
        go1_reg[0] <= obs_grav_x;
        go1_reg[1] <= obs_grav_y;
        go1_reg[2] <= obs_grav_z;
        mo1_reg[0] <= obs_mag_x;
        mo1_reg[1] <= obs_mag_y;
        mo1_reg[2] <= obs_mag_z;
        for (int i = 0; i < 3; i++)
        begin
            g2_reg[i]  <= g1_reg[i];
            m2_reg[i]  <= m1_reg[i];
            go2_reg[i] <= go1_reg[i];
            mo2_reg[i] <= mo1_reg[i];
            n2_reg[i]  <= n2_next[i];
            no2_reg[i] <= no2_next[i];
            go3_reg[i] <= go2_reg[i];
            mo3_reg[i] <= mo2_reg[i];
            n3_reg[i]  <= n2_reg[i];
            no3_reg[i] <= no2_reg[i];
            mn3_reg[i] <= mn3_next[i];
            ng3_reg[i] <= ng3_next[i];
        end
        nn3_reg   <= nn3_next;
        nn4_reg   <= nn3_reg;
        sing4_reg <= (nn3_reg == '0);
        num4_reg  <= num4_next;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                neg_reg[0][i][j] <= neg0_next[i][j];
                sat_reg[0][i][j] <= sat0_next[i][j];
            end
        end
        div_d_reg[0]    <= d0_next;
        div_sing_reg[0] <= sing4_reg;
        for (int s = 0; s <= QBITS; s++)
        begin
            rem_reg[s] <= rem_next[s];
            q_reg[s]   <= q_next[s];
        end
        for (int s = 1; s <= QBITS; s++)
        begin
            neg_reg[s]      <= neg_reg[s-1];
            sat_reg[s]      <= sat_reg[s-1];
            div_d_reg[s]    <= div_d_reg[s-1];
            div_sing_reg[s] <= div_sing_reg[s-1];
        end
        rot_reg      <= rot_next;
        sing_out_reg <= div_sing_reg[QBITS];
    end

    assign done     = done_reg;
    assign singular = sing_out_reg;
    assign rot_00   = rot_reg[0][0];
    assign rot_01   = rot_reg[0][1];
    assign rot_02   = rot_reg[0][2];
    assign rot_10   = rot_reg[1][0];
    assign rot_11   = rot_reg[1][1];
    assign rot_12   = rot_reg[1][2];
    assign rot_20   = rot_reg[2][0];
    assign rot_21   = rot_reg[2][1];
    assign rot_22   = rot_reg[2][2];

    // A finished, nonsingular, unsaturated entry leaves a remainder below the divisor.
    assign div_chk = div_valid_reg[QBITS] && !div_sing_reg[QBITS] && !sat_reg[QBITS][0][0];

    `ASSERT_DELAY(a_latency, clk, rst_n, start, done, 38)
    `ASSERT_DELAY(a_no_extra, clk, rst_n, !start, !done, 38)
    `ASSERT_IMPLY(a_singular_zero, clk, rst_n, done && singular, (rot_00 | rot_11 | rot_22) == 0)
    `ASSERT_IMPLY(a_rem_bound, clk, rst_n, div_chk, rem_reg[QBITS][0][0] < div_d_reg[QBITS])

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    typedef logic signed [127:0] big_t;

    typedef struct {
        logic [tvar_pkg::OW-1:0] rot[9];
        logic                    sing;
    } rotation_t;

    typedef struct {
        int                              phase;
        logic signed [tvar_pkg::SW-1:0]  obs[6];
        bit                              literal;
        rotation_t                       known;
    } stim_row_t;

    localparam logic [2:0] REG_UNUSED_6 = 3'd6;
    localparam logic [2:0] REG_UNUSED_7 = 3'd7;
    localparam logic [tvar_pkg::OW-1:0] ONE_Q824 = 32'h0100_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic signed [tvar_pkg::SW-1:0] obs_grav_x = '0, obs_grav_y = '0, obs_grav_z = '0;
    logic signed [tvar_pkg::SW-1:0] obs_mag_x = '0, obs_mag_y = '0, obs_mag_z = '0;
    logic wr_en = 1'b0;
    logic [2:0] wr_index = '0;
    logic [tvar_pkg::SW-1:0] wr_data = '0;
    logic done, singular;
    logic signed [tvar_pkg::OW-1:0] rot_00, rot_01, rot_02, rot_10, rot_11, rot_12;
    logic signed [tvar_pkg::OW-1:0] rot_20, rot_21, rot_22;

    two_vector_attitude_rotation u_dut (.*);

    always #4 clk = ~clk;

    // Reference vectors as the block holds them: gravity x, y, z then magnetic x, y, z.
    logic signed [tvar_pkg::SW-1:0] ref_vec[6] = '{tvar_pkg::RESET_ZERO, tvar_pkg::RESET_ZERO,
                                                   tvar_pkg::RESET_ONE, tvar_pkg::RESET_ONE,
                                                   tvar_pkg::RESET_ZERO, tvar_pkg::RESET_ZERO};
    rotation_t pending_rotations[$];
    int fail_count = 0;
    stim_row_t directed_rows[$];
    logic signed [tvar_pkg::SW-1:0] phase_refs[4][6];

    function automatic void cross3(input big_t a[3], input big_t b[3], output big_t r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // Rounds num / den * 2^24 to nearest, ties away from zero, with saturation.
    function automatic logic [tvar_pkg::OW-1:0] to_q824(input big_t num, input big_t den);
        logic [127:0] mag, q, d;
        logic neg;
        neg = num < 0;
        mag = neg ? -num : num;
        d = den;
        q = ((mag << 25) + d) / (d << 1);
        if (!neg)
            return (q > 128'h7FFF_FFFF) ? tvar_pkg::SAT_POS : q[tvar_pkg::OW-1:0];
        if (q > 128'h8000_0000)
            return tvar_pkg::SAT_NEG;
        return 32'd0 - q[tvar_pkg::OW-1:0];
    endfunction

    function automatic rotation_t predict_rotation(input logic signed [tvar_pkg::SW-1:0] obs[6]);
        big_t g[3], m[3], go[3], mo[3], n[3], no[3], mn[3], ng[3];
        big_t nn, num;
        rotation_t r;
        for (int i = 0; i < 3; i++)
        begin
            g[i] = ref_vec[i];
            m[i] = ref_vec[3 + i];
            go[i] = obs[i];
            mo[i] = obs[3 + i];
        end
        cross3(m, g, n);
        cross3(mo, go, no);
        nn = n[0] * n[0] + n[1] * n[1] + n[2] * n[2];
        r.sing = (nn == 0);
        if (r.sing)
        begin
            foreach (r.rot[k]) r.rot[k] = '0;
            return r;
        end
        cross3(m, n, mn);
        cross3(n, g, ng);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                num = no[i] * n[j] - go[i] * mn[j] - mo[i] * ng[j];
                r.rot[i * 3 + j] = to_q824(num, nn);
            end
        return r;
    endfunction

    // Keeps the low sample bits of a 32-bit value.
    function automatic logic signed [tvar_pkg::SW-1:0] to_sample(input int v);
        return v[tvar_pkg::SW-1:0];
    endfunction

    task automatic wait_idle();
        start <= 1'b0;
        while (pending_rotations.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes all six reference registers and both unused indexes back to back.
    task automatic load_references(input logic signed [tvar_pkg::SW-1:0] vals[6]);
        for (int k = 0; k < 6; k++)
        begin
            wr_en <= 1'b1;
            wr_index <= tvar_pkg::reg_idx_t'(k);
            wr_data <= vals[k];
            @(posedge clk);
            ref_vec[k] = vals[k];
        end
        wr_index <= REG_UNUSED_6;
        wr_data <= to_sample($urandom);
        @(posedge clk);
        wr_index <= REG_UNUSED_7;
        wr_data <= to_sample($urandom);
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [tvar_pkg::SW-1:0] obs[6], input int gap,
                               input bit literal, input rotation_t known);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        obs_grav_x <= obs[0];
        obs_grav_y <= obs[1];
        obs_grav_z <= obs[2];
        obs_mag_x <= obs[3];
        obs_mag_y <= obs[4];
        obs_mag_z <= obs[5];
        do @(posedge clk); while (busy);
        pending_rotations.push_back(literal ? known : predict_rotation(obs));
    endtask

    function automatic int random_gap();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic signed [tvar_pkg::SW-1:0] random_field();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return -16'sd1;
            default: return to_sample($urandom);
        endcase
    endfunction

    task automatic add_row(input int phase, input logic signed [tvar_pkg::SW-1:0] obs[6],
                           input bit literal, input rotation_t known);
        stim_row_t row;
        row.phase = phase;
        row.obs = obs;
        row.literal = literal;
        row.known = known;
        directed_rows.push_back(row);
    endtask

    logic [tvar_pkg::OW-1:0] got_rot[9];
    rotation_t want;

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got_rot = '{rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22};
            if (pending_rotations.size() == 0)
            begin
                $display("%0t: result with no transaction outstanding", $time);
                fail_count++;
            end
            else
            begin
                want = pending_rotations.pop_front();
                for (int k = 0; k < 9; k++)
                    if (got_rot[k] !== want.rot[k])
                    begin
                        $display("%0t: rot_%0d%0d expected %h actual %h",
                                 $time, k / 3, k % 3, want.rot[k], got_rot[k]);
                        fail_count++;
                    end
                if (singular !== want.sing)
                begin
                    $display("%0t: singular expected %b actual %b",
                             $time, want.sing, singular);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        rotation_t ident, zeros, sing_zero, none;
        logic signed [tvar_pkg::SW-1:0] obs[6], cfg[6];
        int cur_phase, scale;

        foreach (ident.rot[k]) ident.rot[k] = (k % 4 == 0) ? ONE_Q824 : '0;
        ident.sing = 1'b0;
        foreach (zeros.rot[k]) zeros.rot[k] = '0;
        zeros.sing = 1'b0;
        sing_zero = zeros;
        sing_zero.sing = 1'b1;
        none = zeros;

        phase_refs[0] = '{tvar_pkg::RESET_ZERO, tvar_pkg::RESET_ZERO, tvar_pkg::RESET_ONE,
                          tvar_pkg::RESET_ONE, tvar_pkg::RESET_ZERO, tvar_pkg::RESET_ZERO};
        phase_refs[1] = '{16'sd0, 16'sd0, 16'sd1, 16'sd1, 16'sd0, 16'sd0};
        phase_refs[2] = '{16'sd1, 16'sd2, 16'sd3, 16'sd2, 16'sd4, 16'sd6};
        phase_refs[3] = '{-16'sd32768, -16'sd32768, 16'sd32767,
                          16'sd32767, -16'sd32768, -16'sd32768};

        // Reset values: matching observation gives identity, zero observation gives zeros.
        add_row(0, '{16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0}, 1, ident);
        add_row(0, '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0}, 1, zeros);
        add_row(0, '{16'sd0, 16'sd0, -16'sd16384, -16'sd16384, 16'sd0, 16'sd0}, 0, none);
        add_row(0, '{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd16384, 16'sd0}, 0, none);
        add_row(0, '{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
                0, none);
        add_row(0, '{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                     -16'sd32768}, 0, none);
        add_row(0, '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                     -16'sd32768}, 0, none);
        // Unit references: full-scale observations drive entries into saturation, small ones do not.
        add_row(1, '{16'sd0, 16'sd0, 16'sd32767, 16'sd32767, 16'sd0, 16'sd0}, 0, none);
        add_row(1, '{16'sd0, 16'sd0, -16'sd32768, -16'sd32768, 16'sd0, 16'sd0}, 0, none);
        add_row(1, '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                     16'sd32767}, 0, none);
        add_row(1, '{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd1, 16'sd0}, 0, none);
        // Parallel references cannot be inverted (phase 2); phase 3 uses full-scale references.
        add_row(2, '{16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0}, 1, sing_zero);
        add_row(2, '{16'sd32767, -16'sd32768, 16'sd5, 16'sd1, 16'sd2, 16'sd3}, 1, sing_zero);
        add_row(3, '{16'sd0, 16'sd0, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0}, 0, none);
        add_row(3, '{-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768,
                     -16'sd32768}, 0, none);
        add_row(3, '{16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767,
                     16'sd32767}, 0, none);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_phase = 0;
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].phase != cur_phase)
            begin
                cur_phase = directed_rows[r].phase;
                wait_idle();
                load_references(phase_refs[cur_phase]);
            end
            send_sample(directed_rows[r].obs, random_gap(), directed_rows[r].literal,
                        directed_rows[r].known);
        end

        for (int p = 0; p < 8; p++)
        begin
            // The sender waits for every outstanding result before each new reference set.
            wait_idle();
            case (p % 4)
                0: foreach (cfg[k]) cfg[k] = to_sample($urandom_range(1, 7) - 4);
                1:
                begin
                    for (int k = 0; k < 3; k++) cfg[k] = to_sample($urandom_range(200) - 100);
                    scale = $urandom_range(2) - 1;
                    for (int k = 0; k < 3; k++) cfg[3 + k] = to_sample(cfg[k] * scale);
                end
                default: foreach (cfg[k]) cfg[k] = random_field();
            endcase
            load_references(cfg);
            for (int i = 0; i < 130; i++)
            begin
                foreach (obs[k]) obs[k] = random_field();
                send_sample(obs, (p == 3) ? 0 : random_gap(), 0, none);
            end
        end

        start <= 1'b0;
        for (int w = 0; w < 10000 && pending_rotations.size() != 0; w++) @(posedge clk);
        repeat (tvar_pkg::LAT_CYCLES + 10) @(posedge clk);
        if (fail_count == 0 && pending_rotations.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tvar_pkg.sv
hw/rtl/two_vector_attitude_rotation.sv
tb/testbench.sv
